/* rtl/core/fractal_turtle_step_walker_top_assert.svh */
// assertion macros for the turtle step walker
`ifndef FRACTAL_TURTLE_STEP_WALKER_TOP_ASSERT_SVH
`define FRACTAL_TURTLE_STEP_WALKER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define FTSW_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define FTSW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define FTSW_ASSERT_SAME(lbl, ante, cons)
`define FTSW_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* rtl/core/ftsw_pkg.sv */
// types, constants and move tables for the turtle step walker
package ftsw_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int INDEX_WIDTH_DEF = 20;

    localparam int KIND_W     = 2;
    localparam int START_W    = 12;
    localparam int TOTAL_W    = 20;
    localparam int THIRD_W    = 19;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam int OUT_W      = 16;
    localparam int DIR_W      = 3;
    localparam int SYM_W      = 2;
    localparam int COL_W      = 2;

    localparam logic [KIND_W-1:0] KIND_DRAGON = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SIER   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CURVE  = 2'd2;

    localparam logic [SYM_W-1:0] SYM_RIGHT = 2'd0;
    localparam logic [SYM_W-1:0] SYM_LEFT  = 2'd1;
    localparam logic [SYM_W-1:0] SYM_ADV   = 2'd2;
    localparam logic [SYM_W-1:0] SYM_OTHER = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_CURVE_KIND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_X    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL      = 2'd3;

    localparam logic [COL_W-1:0] COL_GREEN  = 2'd0;
    localparam logic [COL_W-1:0] COL_YELLOW = 2'd1;
    localparam logic [COL_W-1:0] COL_RED    = 2'd2;

    localparam logic [KIND_W-1:0]  RST_CURVE_KIND = KIND_DRAGON;
    localparam logic [START_W-1:0] RST_START_X    = 12'd700;
    localparam logic [START_W-1:0] RST_START_Y    = 12'd200;

    localparam logic [1:0] STUB_DRAGON = 2'd1;
    localparam logic [1:0] STUB_SIER   = 2'd2;
    localparam logic [1:0] STUB_CURVE  = 2'd1;

    // ceil(2^21 / 3), exact quotient for any 20 bit value
    localparam logic [TOTAL_W-1:0] DIV3_RECIP = 20'd699051;
    localparam int DIV3_SHIFT = 21;

    typedef struct packed {
        logic                    step;
        logic                    turn;
        logic                    draw;
        logic                    follow;
        logic                    kx;
        logic                    ky;
        logic signed [2:0]       dx;
        logic signed [2:0]       dy;
        logic [DIR_W-1:0]        nd;
    } t_move;

    typedef struct packed {
        logic              draw;
        logic [OUT_W-1:0]  x_from;
        logic [OUT_W-1:0]  y_from;
        logic [OUT_W-1:0]  x_to;
        logic [OUT_W-1:0]  y_to;
        logic [COL_W-1:0]  colour;
        logic [DIR_W-1:0]  heading;
    } t_res;

    function automatic logic [THIRD_W-1:0] f_div3(input logic [TOTAL_W-1:0] v);
        logic [2*TOTAL_W-1:0] prod;
        prod = (2*TOTAL_W)'(v) * (2*TOTAL_W)'(DIV3_RECIP);
        return prod[DIV3_SHIFT +: THIRD_W];
    endfunction

    function automatic logic [1:0] f_stub(input logic [KIND_W-1:0] kind);
        logic [1:0] s;
        s = (kind == KIND_SIER) ? STUB_SIER : ((kind == KIND_CURVE) ? STUB_CURVE : STUB_DRAGON);
        return s;
    endfunction

    function automatic t_move f_mk(input logic signed [2:0] dx, input logic signed [2:0] dy,
                                   input logic kx, input logic ky, input logic [DIR_W-1:0] nd);
        t_move m;
        m        = '0;
        m.step   = 1'b1;
        m.turn   = 1'b1;
        m.kx     = kx;
        m.ky     = ky;
        m.dx     = dx;
        m.dy     = dy;
        m.nd     = nd;
        return m;
    endfunction

    function automatic t_move f_dragon(input logic [1:0] d, input logic s);
        t_move m;
        m = '0;
        unique case ({d, s})
            3'b000: m = f_mk( 3'sd0,  3'sd1, 1'b1, 1'b1, 3'd3);
            3'b001: m = f_mk( 3'sd0, -3'sd1, 1'b1, 1'b1, 3'd2);
            3'b010: m = f_mk( 3'sd0, -3'sd1, 1'b1, 1'b1, 3'd2);
            3'b011: m = f_mk( 3'sd0,  3'sd1, 1'b1, 1'b1, 3'd3);
            3'b100: m = f_mk( 3'sd1,  3'sd0, 1'b1, 1'b1, 3'd0);
            3'b101: m = f_mk(-3'sd1,  3'sd0, 1'b1, 1'b1, 3'd1);
            3'b110: m = f_mk(-3'sd1,  3'sd0, 1'b1, 1'b1, 3'd1);
            3'b111: m = f_mk( 3'sd1,  3'sd0, 1'b1, 1'b1, 3'd0);
            default: m = '0;
        endcase
        return m;
    endfunction

    function automatic t_move f_sier(input logic [DIR_W-1:0] d, input logic s);
        t_move m;
        m = '0;
        unique case ({d, s})
            4'd0:    m = f_mk( 3'sd1,  3'sd2, 1'b0, 1'b0, 3'd5);
            4'd1:    m = f_mk( 3'sd1, -3'sd2, 1'b0, 1'b0, 3'd3);
            4'd2:    m = f_mk(-3'sd1, -3'sd2, 1'b0, 1'b0, 3'd4);
            4'd3:    m = f_mk(-3'sd1,  3'sd2, 1'b0, 1'b0, 3'd2);
            4'd4:    m = f_mk(-3'sd2,  3'sd0, 1'b0, 1'b1, 3'd1);
            4'd5:    m = f_mk( 3'sd1,  3'sd2, 1'b0, 1'b0, 3'd5);
            4'd6:    m = f_mk( 3'sd2,  3'sd0, 1'b0, 1'b1, 3'd0);
            4'd7:    m = f_mk(-3'sd1, -3'sd2, 1'b0, 1'b0, 3'd4);
            4'd8:    m = f_mk( 3'sd1, -3'sd2, 1'b0, 1'b0, 3'd3);
            4'd9:    m = f_mk(-3'sd2,  3'sd0, 1'b0, 1'b1, 3'd1);
            4'd10:   m = f_mk(-3'sd1,  3'sd2, 1'b0, 1'b0, 3'd2);
            4'd11:   m = f_mk( 3'sd2,  3'sd0, 1'b0, 1'b1, 3'd0);
            default: m = '0;
        endcase
        return m;
    endfunction

    function automatic logic [DIR_W-1:0] f_curve_turn(input logic [DIR_W-1:0] d, input logic s);
        logic [DIR_W-1:0] nd;
        nd = '0;
        unique case ({d, s})
            4'd0:  nd = 3'd5;
            4'd1:  nd = 3'd3;
            4'd2:  nd = 3'd4;
            4'd3:  nd = 3'd2;
            4'd4:  nd = 3'd1;
            4'd5:  nd = 3'd7;
            4'd6:  nd = 3'd0;
            4'd7:  nd = 3'd6;
            4'd8:  nd = 3'd6;
            4'd9:  nd = 3'd1;
            4'd10: nd = 3'd7;
            4'd11: nd = 3'd0;
            4'd12: nd = 3'd3;
            4'd13: nd = 3'd4;
            4'd14: nd = 3'd2;
            4'd15: nd = 3'd5;
            default: nd = '0;
        endcase
        return nd;
    endfunction

    function automatic t_move f_curve_adv(input logic [DIR_W-1:0] d);
        t_move m;
        m = '0;
        unique case (d)
            3'd0: m = f_mk( 3'sd3,  3'sd0, 1'b0, 1'b1, d);
            3'd1: m = f_mk(-3'sd3,  3'sd0, 1'b0, 1'b1, d);
            3'd2: m = f_mk(-3'sd3,  3'sd3, 1'b0, 1'b0, d);
            3'd3: m = f_mk( 3'sd3, -3'sd3, 1'b0, 1'b0, d);
            3'd4: m = f_mk(-3'sd3, -3'sd3, 1'b0, 1'b0, d);
            3'd5: m = f_mk( 3'sd3,  3'sd3, 1'b0, 1'b0, d);
            3'd6: m = f_mk( 3'sd0, -3'sd3, 1'b1, 1'b0, d);
            3'd7: m = f_mk( 3'sd0,  3'sd3, 1'b1, 1'b0, d);
            default: m = '0;
        endcase
        return m;
    endfunction

    function automatic t_move f_move(input logic [KIND_W-1:0] kind, input logic [DIR_W-1:0] d,
                                     input logic [SYM_W-1:0] sym);
        t_move m;
        m = '0;
        unique case (kind)
            KIND_DRAGON: begin
                if (!d[2]) begin
                    if (sym == SYM_RIGHT || sym == SYM_LEFT) begin
                        m = f_dragon(d[1:0], sym[0]);
                    end
                    m.draw   = 1'b1;
                    m.follow = 1'b1;
                end
            end
            KIND_SIER: begin
                if (d < 3'd6) begin
                    if (sym == SYM_RIGHT || sym == SYM_LEFT) begin
                        m = f_sier(d, sym[0]);
                    end
                    m.draw   = 1'b1;
                    m.follow = 1'b1;
                end
            end
            KIND_CURVE: begin
                if (sym == SYM_RIGHT || sym == SYM_LEFT) begin
                    m.turn = 1'b1;
                    m.nd   = f_curve_turn(d, sym[0]);
                end else if (sym == SYM_ADV) begin
                    m      = f_curve_adv(d);
                    m.draw = 1'b1;
                end
                m.follow = 1'b1;
            end
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

/* rtl/core/ftsw_if.sv */
// handshake channels of the turtle step walker: symbol requests, results, register writes
interface ftsw_sym_if;
    import ftsw_pkg::*;
    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] symbol;
    logic             restart;
    modport source (output valid, output symbol, output restart, input ready);
    modport sink (input valid, input symbol, input restart, output ready);
endinterface

interface ftsw_res_if;
    import ftsw_pkg::*;
    logic             valid;
    logic             ready;
    logic             draw;
    logic [OUT_W-1:0] x_from;
    logic [OUT_W-1:0] y_from;
    logic [OUT_W-1:0] x_to;
    logic [OUT_W-1:0] y_to;
    logic [COL_W-1:0] colour;
    logic [DIR_W-1:0] heading;
    modport source (output valid, output draw, output x_from, output y_from, output x_to,
                    output y_to, output colour, output heading, input ready);
    modport sink (input valid, input draw, input x_from, input y_from, input x_to,
                  input y_to, input colour, input heading, output ready);
endinterface

interface ftsw_cfg_if;
    import ftsw_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/core/fractal_turtle_step_walker_top.sv */
// top level of the turtle step walker
//
// i_sym carries one request per symbol (turn right, turn left, advance, other)
// with a restart flag that puts the turtle back at the start point first.
// o_res returns exactly one result per request: draw flag, segment endpoints,
// colour third and the heading after the symbol.
// i_cfg writes curve kind, start x, start y and total symbol count; it is
// always ready and takes effect at the next request.
// Throughput is one request per cycle while the skid entry is empty, set by
// the single update of pen, tip, heading and index registers.
// Results go through an output register backed by one skid entry, so a
// stalled receiver costs nothing until both are full; ready then drops.
// Reset loads the register reset values and puts the turtle at the start
// point heading right with index zero; the output side comes up empty.
`include "fractal_turtle_step_walker_top_assert.svh"

module fractal_turtle_step_walker_top #(
    parameter int COORD_WIDTH = ftsw_pkg::COORD_WIDTH_DEF,
    parameter int INDEX_WIDTH = ftsw_pkg::INDEX_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ftsw_sym_if.sink   i_sym,
    ftsw_cfg_if.sink   i_cfg,
    ftsw_res_if.source o_res
);
    import ftsw_pkg::*;

    localparam int EXT_W = (COORD_WIDTH > OUT_W) ? COORD_WIDTH : OUT_W;
    localparam int CMP_W = (INDEX_WIDTH > THIRD_W + 2) ? INDEX_WIDTH : THIRD_W + 2;
    localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    function automatic logic signed [COORD_WIDTH-1:0] f_sat_start(input logic [START_W:0] v);
        logic signed [COORD_WIDTH-1:0] c;
        if (32'(v) > 32'(COORD_MAX)) begin
            c = COORD_MAX;
        end else begin
            c = COORD_WIDTH'(v);
        end
        return c;
    endfunction

    function automatic logic signed [COORD_WIDTH-1:0] f_add_sat(
        input logic signed [COORD_WIDTH-1:0] base, input logic signed [2:0] delta);
        logic signed [COORD_WIDTH:0] sum;
        logic signed [COORD_WIDTH-1:0] c;
        sum = (COORD_WIDTH+1)'(base) + (COORD_WIDTH+1)'(delta);
        if (sum[COORD_WIDTH] != sum[COORD_WIDTH-1]) begin
            c = sum[COORD_WIDTH] ? COORD_MIN : COORD_MAX;
        end else begin
            c = sum[COORD_WIDTH-1:0];
        end
        return c;
    endfunction

    function automatic logic [OUT_W-1:0] f_out(input logic signed [COORD_WIDTH-1:0] c);
        logic signed [EXT_W-1:0] e;
        e = EXT_W'(c);
        return e[OUT_W-1:0];
    endfunction

    // configuration
    logic [KIND_W-1:0]  r_kind;
    logic [START_W-1:0] r_start_x;
    logic [START_W-1:0] r_start_y;
    logic [THIRD_W-1:0] r_third;

    // walk state
    logic signed [COORD_WIDTH-1:0] r_pen_x, r_pen_y, r_tip_x, r_tip_y;
    logic [DIR_W-1:0]              r_dir;
    logic [INDEX_WIDTH-1:0]        r_idx;

    // output register and skid entry
    logic r_out_valid, r_skid_valid;
    t_res r_out, r_skid;

    logic                          in_acc;
    logic                          out_take;
    logic signed [COORD_WIDTH-1:0] init_px, init_py, init_tx;
    logic signed [COORD_WIDTH-1:0] cur_px, cur_py, cur_tx, cur_ty;
    logic [DIR_W-1:0]              cur_dir;
    logic [INDEX_WIDTH-1:0]        cur_idx;
    t_move                         mv;
    logic signed [COORD_WIDTH-1:0] n_tip_x, n_tip_y, n_pen_x, n_pen_y;
    logic [DIR_W-1:0]              n_dir;
    logic [INDEX_WIDTH-1:0]        n_idx;
    logic [COL_W-1:0]              colour;
    t_res                          n_res;

    assign in_acc      = i_sym.valid && i_sym.ready;
    assign out_take    = r_out_valid && o_res.ready;
    assign i_sym.ready = !r_skid_valid;
    assign i_cfg.ready = 1'b1;

    // start point from current registers
    assign init_px = f_sat_start({1'b0, r_start_x});
    assign init_py = f_sat_start({1'b0, r_start_y});
    assign init_tx = f_sat_start({1'b0, r_start_x} + (START_W+1)'(f_stub(r_kind)));

    always_comb begin
        cur_px  = i_sym.restart ? init_px : r_pen_x;
        cur_py  = i_sym.restart ? init_py : r_pen_y;
        cur_tx  = i_sym.restart ? init_tx : r_tip_x;
        cur_ty  = i_sym.restart ? init_py : r_tip_y;
        cur_dir = i_sym.restart ? '0 : r_dir;
        cur_idx = i_sym.restart ? '0 : r_idx;

        mv = f_move(r_kind, cur_dir, i_sym.symbol);

        n_tip_x = mv.step ? f_add_sat(mv.kx ? cur_tx : cur_px, mv.dx) : cur_tx;
        n_tip_y = mv.step ? f_add_sat(mv.ky ? cur_ty : cur_py, mv.dy) : cur_ty;
        n_pen_x = mv.follow ? n_tip_x : cur_px;
        n_pen_y = mv.follow ? n_tip_y : cur_py;
        n_dir   = mv.turn ? mv.nd : cur_dir;
        n_idx   = (&cur_idx) ? cur_idx : cur_idx + 1'b1;

        priority if (CMP_W'(cur_idx) < CMP_W'(r_third)) begin
            colour = COL_GREEN;
        end else if (CMP_W'(cur_idx) < CMP_W'({r_third, 1'b0})) begin
            colour = COL_YELLOW;
        end else begin
            colour = COL_RED;
        end

        n_res.draw    = mv.draw;
        n_res.x_from  = f_out(cur_px);
        n_res.y_from  = f_out(cur_py);
        n_res.x_to    = f_out(n_tip_x);
        n_res.y_to    = f_out(n_tip_y);
        n_res.colour  = colour;
        n_res.heading = n_dir;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind    <= RST_CURVE_KIND;
            r_start_x <= RST_START_X;
            r_start_y <= RST_START_Y;
            r_third   <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                REG_CURVE_KIND: r_kind    <= i_cfg.data[KIND_W-1:0];
                REG_START_X:    r_start_x <= i_cfg.data[START_W-1:0];
                REG_START_Y:    r_start_y <= i_cfg.data[START_W-1:0];
                REG_TOTAL:      r_third   <= f_div3(i_cfg.data[TOTAL_W-1:0]);
                default:        r_kind    <= r_kind;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_x <= f_sat_start({1'b0, RST_START_X});
            r_pen_y <= f_sat_start({1'b0, RST_START_Y});
            r_tip_x <= f_sat_start({1'b0, RST_START_X} + (START_W+1)'(f_stub(RST_CURVE_KIND)));
            r_tip_y <= f_sat_start({1'b0, RST_START_Y});
            r_dir   <= '0;
            r_idx   <= '0;
        end else if (in_acc) begin
            r_pen_x <= n_pen_x;
            r_pen_y <= n_pen_y;
            r_tip_x <= n_tip_x;
            r_tip_y <= n_tip_y;
            r_dir   <= n_dir;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_acc;
            end
        end else if (in_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            r_out <= r_skid_valid ? r_skid : n_res;
        end else if (in_acc) begin
            r_skid <= n_res;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.draw    = r_out.draw;
    assign o_res.x_from  = r_out.x_from;
    assign o_res.y_from  = r_out.y_from;
    assign o_res.x_to    = r_out.x_to;
    assign o_res.y_to    = r_out.y_to;
    assign o_res.colour  = r_out.colour;
    assign o_res.heading = r_out.heading;

    `FTSW_ASSERT_SAME(a_skid_behind_out, r_skid_valid, r_out_valid)
    `FTSW_ASSERT_NEXT(a_stall_fills_skid, in_acc && r_out_valid && !o_res.ready, r_skid_valid)
    `FTSW_ASSERT_NEXT(a_idx_monotonic, in_acc && !i_sym.restart, r_idx >= $past(r_idx))

endmodule

/* verif/fractal_turtle_step_walker_top_tb.sv */
// self-checking testbench for the turtle step walker: directed table, random walks, corner walks
`timescale 1ns / 1ps

module fractal_turtle_step_walker_top_tb;
    import ftsw_pkg::*;

    localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
    localparam int COORD_HI = (1 << (OUT_W - 1)) - 1;
    localparam int COORD_LO = -COORD_HI - 1;
    localparam int unsigned STEP_CAP = (1 << INDEX_WIDTH_DEF) - 1;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int REPORT_CAP = 40;
    localparam int PHASE_ITEMS = 28;

    // move tables, indexed by 2 * heading + (symbol is a left turn)
    localparam int DRG_DX [8] = '{0, 0, 0, 0, 1, -1, -1, 1};
    localparam int DRG_DY [8] = '{1, -1, -1, 1, 0, 0, 0, 0};
    localparam int DRG_ND [8] = '{3, 2, 2, 3, 0, 1, 1, 0};
    localparam int SRP_DX [12] = '{1, 1, -1, -1, -2, 1, 2, -1, 1, -2, -1, 2};
    localparam int SRP_DY [12] = '{2, -2, -2, 2, 0, 2, 0, -2, -2, 0, 2, 0};
    localparam int SRP_KY [12] = '{0, 0, 0, 0, 1, 0, 1, 0, 0, 1, 0, 1};
    localparam int SRP_ND [12] = '{5, 3, 4, 2, 1, 5, 0, 4, 3, 1, 2, 0};
    localparam int CRV_TURN [16] = '{5, 3, 4, 2, 1, 7, 0, 6, 6, 1, 7, 0, 3, 4, 2, 5};
    // curve advance, indexed by heading
    localparam int CRV_DX [8] = '{3, -3, -3, 3, -3, 3, 0, 0};
    localparam int CRV_DY [8] = '{0, 0, 3, -3, -3, 3, -3, 3};
    localparam int CRV_KX [8] = '{0, 0, 0, 0, 0, 0, 1, 1};
    localparam int CRV_KY [8] = '{1, 1, 0, 0, 0, 0, 0, 0};

    typedef enum logic {ROW_SYM, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  sel;
        logic [CFG_DATA_W-1:0] value;
        logic [SYM_W-1:0]      sym;
        logic                  rs;
        logic                  pinned;
        t_res                  seg;
    } t_row;

    localparam t_res NO_SEG = '0;
    localparam logic [CFG_DATA_W-1:0] V_DRAGON = CFG_DATA_W'(KIND_DRAGON);
    localparam logic [CFG_DATA_W-1:0] V_SIER   = CFG_DATA_W'(KIND_SIER);
    localparam logic [CFG_DATA_W-1:0] V_CURVE  = CFG_DATA_W'(KIND_CURVE);
    localparam logic [CFG_DATA_W-1:0] V_NONE   = CFG_DATA_W'(KIND_NONE);

    localparam t_row DIRECTED_PLAN [41] = '{
        '{ROW_SYM, REG_CURVE_KIND, 20'd0, SYM_RIGHT, 1'b0, 1'b1,
          '{1'b1, 16'd700, 16'd200, 16'd701, 16'd201, COL_RED, 3'd3}},
        '{ROW_SYM, REG_CURVE_KIND, 20'd0, SYM_LEFT, 1'b0, 1'b1,
          '{1'b1, 16'd701, 16'd201, 16'd702, 16'd201, COL_RED, 3'd0}},
        '{ROW_SYM, REG_CURVE_KIND, 20'd0, SYM_ADV, 1'b0, 1'b1,
          '{1'b1, 16'd702, 16'd201, 16'd702, 16'd201, COL_RED, 3'd0}},
        '{ROW_SYM, REG_CURVE_KIND, 20'd0, SYM_OTHER, 1'b0, 1'b0, NO_SEG},
        '{ROW_SYM, REG_CURVE_KIND, 20'd0, SYM_LEFT, 1'b0, 1'b0, NO_SEG},
        '{ROW_SYM, REG_CURVE_KIND, 20'd0, SYM_RIGHT, 1'b1, 1'b1,
          '{1'b1, 16'd700, 16'd200, 16'd701, 16'd201, COL_RED, 3'd3}},
        '{ROW_CFG, REG_TOTAL, 20'd9, SYM_RIGHT, 1'b0, 1'b0, NO_SEG},
        '{ROW_CFG, REG_CURVE_KIND, V_SIER, SYM_RIGHT, 1'b0, 1'b0, NO_SEG},
        '{ROW_CFG, REG_START_X, 20'd4095, SYM_RIGHT, 1'b0, 1'b0, NO_SEG},
        '{ROW_CFG, REG_START_Y, 20'd0, SYM_RIGHT, 1'b0, 1'b0, NO_SEG},
        '{ROW_SYM, REG_CURVE_KIND, 20'd0, SYM_RIGHT, 1'b1, 1'b1,
          '{1'b1, 16'd4095, 16'd0, 16'd4096, 16'd2, COL_GREEN, 3'd5}},
        '{ROW_SYM, REG_CURVE_KIND, 20'd0, SYM_LEFT, 1'b0, 1'b0, NO_SEG},
        '{ROW_SYM, REG_CURVE_KIND, 20'd0, SYM_ADV, 1'b0, 1'b0, NO_SEG},
        '{ROW_SYM, REG_CURVE_KIND, 20'd0, SYM_OTHER, 1'b0, 1'b0, NO_SEG},
        '{ROW_SYM, REG_CURVE_KIND, 20'd0, SYM_RIGHT, 1'b0, 1'b0, NO_SEG},
        '{ROW_SYM, REG_CURVE_KIND, 20'd0, SYM_LEFT, 1'b0, 1'b0, NO_SEG},
        '{ROW_CFG, REG_CURVE_KIND, V_CURVE, SYM_RIGHT, 1'b0, 1'b0, NO_SEG},
        '{ROW_CFG, REG_START_X, 20'd0, SYM_RIGHT, 1'b0, 1'b0, NO_SEG},
        '{ROW_CFG, REG_START_Y, 20'd4095, SYM_RIGHT, 1'b0, 1'b0, NO_SEG},
        '{ROW_SYM, REG_CURVE_KIND, 20'd0, SYM_OTHER, 1'b1, 1'b1,
          '{1'b0, 16'd0, 16'd4095, 16'd1, 16'd4095, COL_GREEN, 3'd0}},
        '{ROW_SYM, REG_CURVE_KIND, 20'd0, SYM_ADV, 1'b0, 1'b0, NO_SEG},
        '{ROW_SYM, REG_CURVE_KIND, 20'd0, SYM_RIGHT, 1'b0, 1'b0, NO_SEG},
        '{ROW_SYM, REG_CURVE_KIND, 20'd0, SYM_ADV, 1'b0, 1'b0, NO_SEG},
        '{ROW_SYM, REG_CURVE_KIND, 20'd0, SYM_LEFT, 1'b0, 1'b0, NO_SEG},
        '{ROW_SYM, REG_CURVE_KIND, 20'd0, SYM_LEFT, 1'b0, 1'b0, NO_SEG},
        '{ROW_SYM, REG_CURVE_KIND, 20'd0, SYM_LEFT, 1'b0, 1'b0, NO_SEG},
        '{ROW_SYM, REG_CURVE_KIND, 20'd0, SYM_ADV, 1'b0, 1'b0, NO_SEG},
        '{ROW_CFG, REG_CURVE_KIND, V_DRAGON, SYM_RIGHT, 1'b0, 1'b0, NO_SEG},
        '{ROW_SYM, REG_CURVE_KIND, 20'd0, SYM_RIGHT, 1'b0, 1'b0, NO_SEG},
        '{ROW_SYM, REG_CURVE_KIND, 20'd0, SYM_ADV, 1'b0, 1'b0, NO_SEG},
        '{ROW_CFG, REG_CURVE_KIND, V_SIER, SYM_RIGHT, 1'b0, 1'b0, NO_SEG},
        '{ROW_SYM, REG_CURVE_KIND, 20'd0, SYM_LEFT, 1'b0, 1'b0, NO_SEG},
        '{ROW_CFG, REG_CURVE_KIND, V_NONE, SYM_RIGHT, 1'b0, 1'b0, NO_SEG},
        '{ROW_SYM, REG_CURVE_KIND, 20'd0, SYM_RIGHT, 1'b1, 1'b1,
          '{1'b0, 16'd0, 16'd4095, 16'd1, 16'd4095, COL_GREEN, 3'd0}},
        '{ROW_SYM, REG_CURVE_KIND, 20'd0, SYM_ADV, 1'b0, 1'b0, NO_SEG},
        '{ROW_CFG, REG_TOTAL, 20'd1048575, SYM_RIGHT, 1'b0, 1'b0, NO_SEG},
        '{ROW_CFG, REG_CURVE_KIND, V_DRAGON, SYM_RIGHT, 1'b0, 1'b0, NO_SEG},
        '{ROW_CFG, REG_START_X, 20'd4095, SYM_RIGHT, 1'b0, 1'b0, NO_SEG},
        '{ROW_CFG, REG_START_Y, 20'd4095, SYM_RIGHT, 1'b0, 1'b0, NO_SEG},
        '{ROW_SYM, REG_CURVE_KIND, 20'd0, SYM_LEFT, 1'b1, 1'b1,
          '{1'b1, 16'd4095, 16'd4095, 16'd4096, 16'd4094, COL_GREEN, 3'd2}},
        '{ROW_SYM, REG_CURVE_KIND, 20'd0, SYM_RIGHT, 1'b0, 1'b0, NO_SEG}
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ftsw_sym_if sym_ch ();
    ftsw_cfg_if cfg_ch ();
    ftsw_res_if res_ch ();

    fractal_turtle_step_walker_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sym   (sym_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // walk state and register copy of the predictor
    logic [KIND_W-1:0]  walk_kind;
    logic [START_W-1:0] home_x;
    logic [START_W-1:0] home_y;
    logic [TOTAL_W-1:0] seq_len;
    int                 at_x, at_y, nose_x, nose_y;
    logic [DIR_W-1:0]   facing;
    int unsigned        steps_taken;

    t_res segments_due [$];
    bit   pin_on = 1'b0;
    t_res pin_seg = '0;
    int   src_idle_pct = 34;
    int   sink_idle_pct = 49;
    int   mismatches = 0;
    int   symbols_taken = 0;
    int   segments_checked = 0;
    int   clamp_hits = 0;
    int   frozen_hits = 0;
    int   stall_cycles = 0;

    function automatic int clamp_coord(input int v);
        if (v > COORD_HI) return COORD_HI;
        if (v < COORD_LO) return COORD_LO;
        return v;
    endfunction

    function automatic void move_nose(input int dx, input int dy, input int kx, input int ky);
        int nx, ny;
        nx = ((kx != 0) ? nose_x : at_x) + dx;
        ny = ((ky != 0) ? nose_y : at_y) + dy;
        if (nx != clamp_coord(nx) || ny != clamp_coord(ny)) clamp_hits++;
        nose_x = clamp_coord(nx);
        nose_y = clamp_coord(ny);
    endfunction

    function automatic void home_walk();
        at_x = int'(home_x);
        at_y = int'(home_y);
        nose_x = at_x + ((walk_kind == KIND_SIER) ? int'(STUB_SIER) : int'(STUB_DRAGON));
        nose_y = at_y;
        facing = '0;
        steps_taken = 0;
    endfunction

    function automatic t_res walk_symbol(input logic [SYM_W-1:0] s, input logic rs);
        t_res r;
        int unsigned third;
        int k;
        bit turning;
        if (rs) home_walk();
        third = seq_len / 3;
        r = '0;
        r.colour = (steps_taken < third) ? COL_GREEN
                 : ((steps_taken < 2 * third) ? COL_YELLOW : COL_RED);
        r.x_from = OUT_W'(at_x);
        r.y_from = OUT_W'(at_y);
        turning = (s == SYM_RIGHT) || (s == SYM_LEFT);
        k = 2 * int'(facing) + int'(s[0]);
        if (walk_kind == KIND_DRAGON && facing < 3'd4) begin
            if (turning) begin
                move_nose(DRG_DX[k], DRG_DY[k], 1, 1);
                facing = DIR_W'(DRG_ND[k]);
            end
            r.draw = 1'b1;
            at_x = nose_x;
            at_y = nose_y;
        end else if (walk_kind == KIND_SIER && facing < 3'd6) begin
            if (turning) begin
                move_nose(SRP_DX[k], SRP_DY[k], 0, SRP_KY[k]);
                facing = DIR_W'(SRP_ND[k]);
            end
            r.draw = 1'b1;
            at_x = nose_x;
            at_y = nose_y;
        end else if (walk_kind == KIND_CURVE) begin
            if (turning) begin
                facing = DIR_W'(CRV_TURN[k]);
            end else if (s == SYM_ADV) begin
                move_nose(CRV_DX[facing], CRV_DY[facing], CRV_KX[facing], CRV_KY[facing]);
                r.draw = 1'b1;
            end
            at_x = nose_x;
            at_y = nose_y;
        end else begin
            frozen_hits++;
        end
        r.x_to = OUT_W'(nose_x);
        r.y_to = OUT_W'(nose_y);
        r.heading = facing;
        if (steps_taken < STEP_CAP) steps_taken++;
        return r;
    endfunction

    function automatic void compare_segment(input t_res want, input t_res got);
        if (got === want) return;
        mismatches++;
        if (mismatches > REPORT_CAP) return;
        if (got.draw !== want.draw)
            $error("draw: expected %0d, got %0d", want.draw, got.draw);
        if (got.x_from !== want.x_from)
            $error("x_from: expected %0d, got %0d", $signed(want.x_from), $signed(got.x_from));
        if (got.y_from !== want.y_from)
            $error("y_from: expected %0d, got %0d", $signed(want.y_from), $signed(got.y_from));
        if (got.x_to !== want.x_to)
            $error("x_to: expected %0d, got %0d", $signed(want.x_to), $signed(got.x_to));
        if (got.y_to !== want.y_to)
            $error("y_to: expected %0d, got %0d", $signed(want.y_to), $signed(got.y_to));
        if (got.colour !== want.colour)
            $error("colour: expected %0d, got %0d", want.colour, got.colour);
        if (got.heading !== want.heading)
            $error("heading: expected %0d, got %0d", want.heading, got.heading);
    endfunction

    always @(negedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        bit moved;
        if (!i_rst_n) begin
            walk_kind = RST_CURVE_KIND;
            home_x = RST_START_X;
            home_y = RST_START_Y;
            seq_len = '0;
            home_walk();
            segments_due.delete();
            stall_cycles = 0;
        end else begin
            moved = 1'b0;
            if (cfg_ch.valid && cfg_ch.ready) begin
                moved = 1'b1;
                case (cfg_ch.index)
                    REG_CURVE_KIND: walk_kind = cfg_ch.data[KIND_W-1:0];
                    REG_START_X:    home_x = cfg_ch.data[START_W-1:0];
                    REG_START_Y:    home_y = cfg_ch.data[START_W-1:0];
                    REG_TOTAL:      seq_len = cfg_ch.data[TOTAL_W-1:0];
                    default: ;
                endcase
            end
            if (res_ch.valid && res_ch.ready) begin
                moved = 1'b1;
                got = '{res_ch.draw, res_ch.x_from, res_ch.y_from, res_ch.x_to, res_ch.y_to,
                        res_ch.colour, res_ch.heading};
                if (segments_due.size() == 0) begin
                    mismatches++;
                    $error("segment returned with no symbol outstanding");
                end else begin
                    compare_segment(segments_due.pop_front(), got);
                    segments_checked++;
                end
            end
            if (sym_ch.valid && sym_ch.ready) begin
                moved = 1'b1;
                want = walk_symbol(sym_ch.symbol, sym_ch.restart);
                if (pin_on) want = pin_seg;
                segments_due.push_back(want);
                symbols_taken++;
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
                $display("fractal_turtle_step_walker_top test failed");
                $finish;
            end
        end
    end

    task automatic push_symbol(input logic [SYM_W-1:0] s, input logic rs, input bit pin,
                               input t_res seg);
        cfg_ch.valid <= 1'b0;
        while ($urandom_range(99) < src_idle_pct) begin
            sym_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        pin_on = pin;
        pin_seg = seg;
        sym_ch.valid <= 1'b1;
        sym_ch.symbol <= s;
        sym_ch.restart <= rs;
        @(posedge i_clk);
        while (!sym_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        sym_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (segments_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= sel;
        cfg_ch.data <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [START_W-1:0] pick_origin();
        if ($urandom_range(3) == 0) return $urandom_range(1) ? {START_W{1'b1}} : {START_W{1'b0}};
        return START_W'($urandom);
    endfunction

    task automatic random_setup();
        logic [KIND_W-1:0] kind;
        logic [TOTAL_W-1:0] total;
        kind = ($urandom_range(9) == 0) ? KIND_NONE : KIND_W'($urandom_range(2));
        total = ($urandom_range(5) == 0) ? TOTAL_W'($urandom) : TOTAL_W'($urandom_range(60, 3));
        wait_drained();
        write_reg(REG_CURVE_KIND, CFG_DATA_W'(kind));
        write_reg(REG_START_X, CFG_DATA_W'(pick_origin()));
        write_reg(REG_START_Y, CFG_DATA_W'(pick_origin()));
        write_reg(REG_TOTAL, CFG_DATA_W'(total));
    endtask

    task automatic random_walk(input int count, input bit hold_midway);
        for (int i = 0; i < count; i++) begin
            if (hold_midway && i == count / 2) wait_drained();
            push_symbol(SYM_W'($urandom_range(3)), ($urandom_range(15) == 0), 1'b0, NO_SEG);
        end
    endtask

    // curve walk leaving a corner of the start range, then random symbols
    task automatic clamp_climb(input logic [START_W-1:0] origin, input int left_turns,
                               input int advances);
        wait_drained();
        write_reg(REG_CURVE_KIND, V_CURVE);
        write_reg(REG_START_X, CFG_DATA_W'(origin));
        write_reg(REG_START_Y, CFG_DATA_W'(origin));
        if (left_turns == 0) begin
            push_symbol(SYM_RIGHT, 1'b1, 1'b0, NO_SEG);
        end else begin
            for (int i = 0; i < left_turns; i++)
                push_symbol(SYM_LEFT, (i == 0), 1'b0, NO_SEG);
        end
        repeat (advances) push_symbol(SYM_ADV, 1'b0, 1'b0, NO_SEG);
        random_walk(20, 1'b0);
    endtask

    initial begin
        bit after_sym;
        sym_ch.valid <= 1'b0;
        sym_ch.symbol <= SYM_RIGHT;
        sym_ch.restart <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= REG_CURVE_KIND;
        cfg_ch.data <= '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        after_sym = 1'b1;
        foreach (DIRECTED_PLAN[i]) begin
            if (DIRECTED_PLAN[i].kind == ROW_CFG) begin
                if (after_sym) wait_drained();
                write_reg(DIRECTED_PLAN[i].sel, DIRECTED_PLAN[i].value);
                after_sym = 1'b0;
            end else begin
                push_symbol(DIRECTED_PLAN[i].sym, DIRECTED_PLAN[i].rs,
                            DIRECTED_PLAN[i].pinned, DIRECTED_PLAN[i].seg);
                after_sym = 1'b1;
            end
        end

        // receiver-heavy idling, then sender-heavy, then none
        for (int p = 0; p < 12; p++) begin
            random_setup();
            if (p == 4) begin
                src_idle_pct = 49;
                sink_idle_pct = 34;
            end else if (p == 8) begin
                src_idle_pct = 0;
                sink_idle_pct = 0;
            end
            random_walk(PHASE_ITEMS, (p == 5));
        end

        clamp_climb({START_W{1'b1}}, 0, 8);
        clamp_climb({START_W{1'b0}}, 3, 8);

        wait_drained();
        cfg_ch.valid <= 1'b0;
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("%0d symbols walked in all curve kinds under three idling patterns",
                 symbols_taken);
        $display("%0d segments compared, %0d clamped moves, %0d frozen-heading steps",
                 segments_checked, clamp_hits, frozen_hits);
        if (mismatches == 0) begin
            $display("fractal_turtle_step_walker_top test passed");
        end else begin
            $display("fractal_turtle_step_walker_top test failed");
        end
        $finish;
    end

endmodule

/* fractal_turtle_step_walker_top.f */
+incdir+rtl/core
rtl/core/ftsw_pkg.sv
rtl/core/ftsw_if.sv
rtl/core/fractal_turtle_step_walker_top.sv
verif/fractal_turtle_step_walker_top_tb.sv
